>>> design/bnprs_pkg.sv
package bnprs_pkg;

  localparam int unsigned MaxNodes   = 16;
  localparam int unsigned NodeW      = $clog2(MaxNodes);
  localparam int unsigned CountW     = NodeW + 1;
  localparam int unsigned PeriodW    = 26;
  localparam int unsigned LimitW     = 8;
  localparam int unsigned WaitCntW   = 9;
  localparam int unsigned OpCntW     = 2;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = PeriodW;
  localparam int unsigned NodeCountW = 5;

  localparam logic [PeriodW-1:0]    PeriodReset     = PeriodW'(500000);
  localparam logic [LimitW-1:0]     InnerLimitReset = LimitW'(10);
  localparam logic [LimitW-1:0]     OuterLimitReset = LimitW'(10);
  localparam logic [LimitW-1:0]     InnerLimitMin   = LimitW'(3);
  localparam logic [LimitW-1:0]     OuterLimitMin   = LimitW'(2);
  localparam logic [NodeCountW-1:0] NodeCountReset  = '0;
  localparam logic [NodeCountW-1:0] NodeCountMax    = NodeCountW'(MaxNodes);
  localparam logic [OpCntW-1:0]     OpsPerNodeLast  = OpCntW'(3);

  localparam logic [StatusW-1:0] StatusSuccess = 2'd0;
  localparam logic [StatusW-1:0] StatusWaiting = 2'd1;

  localparam logic [CfgIdxW-1:0] CfgCyclePeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaitInner   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaitOuter   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNodeCount   = 2'd3;

endpackage

>>> design/bnprs_if.sv
interface bnprs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bnprs_pkg::TimeW-1:0]          now_us;
  logic [bnprs_pkg::StatusW-1:0]        last_status;

  modport source (output valid, output now_us, output last_status, input ready);
  modport sink (input valid, input now_us, input last_status, output ready);
endinterface

interface bnprs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bnprs_pkg::NodeW-1:0]          node_index;
  logic                                 cycle_started;
  logic                                 node_advanced;

  modport source (output valid, output node_index, output cycle_started,
                  output node_advanced, input ready);
  modport sink (input valid, input node_index, input cycle_started,
                input node_advanced, output ready);
endinterface

>>> design/bus_node_poll_retry_scheduler.sv
// Round-robin poll scheduler for up to 16 bus nodes. Every input beat carries the
// current microsecond time and the last transaction status, and yields exactly
// one output beat with the polled node index and the cycle-start and advance
// flags. A beat is taken every clock: the whole update is one time compare and
// a few counter steps between the state registers and a single output register,
// and a new beat is accepted whenever that register is empty or being drained.
// Write the configuration registers only while no beat is in flight.
module bus_node_poll_retry_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bnprs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bnprs_pkg::CfgDataW-1:0]      cfg_data_i,
  bnprs_in_if.sink                            in_i,
  bnprs_out_if.source                         out_o
);
  import bnprs_pkg::*;

  logic [PeriodW-1:0]    period_q;
  logic [LimitW-1:0]     lim_in_q, lim_out_q;
  logic [NodeCountW-1:0] nodes_q;

  logic [TimeW-1:0]    start_q, start_d;
  logic [WaitCntW-1:0] inner_q, inner_d, outer_q, outer_d;
  logic [OpCntW-1:0]   ops_q, ops_d;
  logic [NodeW-1:0]    node_q, node_d;

  logic                out_valid_q;
  logic [NodeW-1:0]    out_node_q;
  logic                out_started_q, out_adv_q;

  logic                accept;
  logic [CountW-1:0]   count;
  logic [NodeW-1:0]    node_base;
  logic [CountW-1:0]   node_inc;
  logic [NodeW-1:0]    node_next;
  logic                due;
  logic                started, advanced;
  logic [LimitW-1:0]   cfg_lim;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign count     = (nodes_q > NodeCountMax) ? CountW'(NodeCountMax) : CountW'(nodes_q);
  assign node_base = ({1'b0, node_q} >= count) ? '0 : node_q;
  assign node_inc  = {1'b0, node_base} + CountW'(1);
  assign node_next = (node_inc >= count) ? '0 : node_inc[NodeW-1:0];
  assign due       = (in_i.now_us - start_q) >= {{(TimeW-PeriodW){1'b0}}, period_q};
  assign cfg_lim   = cfg_data_i[LimitW-1:0];

  always_comb begin
    start_d  = start_q;
    inner_d  = inner_q;
    outer_d  = outer_q;
    ops_d    = ops_q;
    node_d   = node_base;
    started  = 1'b0;
    advanced = 1'b0;
    if (due) begin
      start_d = in_i.now_us;
      started = 1'b1;
      if (count != '0) begin
        if (in_i.last_status == StatusWaiting) begin
          if (inner_q > {1'b0, lim_in_q}) begin
            inner_d = '0;
            outer_d = outer_q + WaitCntW'(1);
          end else begin
            inner_d = inner_q + WaitCntW'(1);
          end
          if (outer_d > {1'b0, lim_out_q}) begin
            inner_d  = '0;
            outer_d  = '0;
            ops_d    = '0;
            node_d   = node_next;
            advanced = 1'b1;
          end
        end else begin
          inner_d = '0;
          outer_d = '0;
        end
        if (in_i.last_status == StatusSuccess) begin
          if (ops_q < OpsPerNodeLast) begin
            ops_d = ops_q + OpCntW'(1);
          end else begin
            ops_d    = '0;
            node_d   = node_next;
            advanced = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PeriodReset;
      lim_in_q  <= InnerLimitReset;
      lim_out_q <= OuterLimitReset;
      nodes_q   <= NodeCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCyclePeriod: period_q  <= cfg_data_i;
        CfgWaitInner:   lim_in_q  <= (cfg_lim < InnerLimitMin) ? InnerLimitMin : cfg_lim;
        CfgWaitOuter:   lim_out_q <= (cfg_lim < OuterLimitMin) ? OuterLimitMin : cfg_lim;
        CfgNodeCount:   nodes_q   <= cfg_data_i[NodeCountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      inner_q <= '0;
      outer_q <= '0;
      ops_q   <= '0;
      node_q  <= '0;
    end else if (accept) begin
      start_q <= start_d;
      inner_q <= inner_d;
      outer_q <= outer_d;
      ops_q   <= ops_d;
      node_q  <= node_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_node_q    <= node_d;
      out_started_q <= started;
      out_adv_q     <= advanced;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.node_index    = out_node_q;
  assign out_o.cycle_started = out_started_q;
  assign out_o.node_advanced = out_adv_q;

endmodule
